### rtl/rmfh_pkg.sv
// Shared types, sizes and helpers for the recursive mutex with FIFO wait queue.
// Used by every module of the block but rmfh_wait_ram; depends on nothing.
`default_nettype none
package rmfh_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int MAX_DEPTH  = 255;

    localparam int TASK_W  = 4;
    localparam int STAT_W  = 4;
    localparam int LDEP_W  = 8;
    localparam int PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    typedef enum logic [STAT_W-1:0] {
        ST_ACQUIRED   = 4'd0,
        ST_RELOCKED   = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_QFULL      = 4'd3,
        ST_SATURATED  = 4'd4,
        ST_STILL_HELD = 4'd5,
        ST_FREED      = 4'd6,
        ST_HANDOFF    = 4'd7,
        ST_NOT_OWNER  = 4'd8
    } t_status;

    typedef enum logic {
        CMD_LOCK   = 1'b0,
        CMD_UNLOCK = 1'b1
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic                woken_valid;
        logic [TASK_W-1:0]   woken_task;
        logic [LDEP_W-1:0]   lock_depth;
        logic [TASK_W-1:0]   owner_task;
        logic                owned;
    } t_result;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] last;
        last = PTR_W'(WAIT_DEPTH - 1);
        return (p >= last) ? '0 : p + PTR_W'(1);
    endfunction

    // low byte of the depth count, zero-extended when the count is narrower
    function automatic logic [LDEP_W-1:0] to_lock_depth(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W+LDEP_W-1:0] wide;
        wide = {{LDEP_W{1'b0}}, d};
        return wide[LDEP_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/rmfh_wait_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the wait queue entries; no package dependency.
`default_nettype none
module rmfh_wait_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/rmfh_ctrl.sv
// Mutex state and request sequencer: owner, depth and queue pointers, with the
// wait queue kept in rmfh_wait_ram. Depends on rmfh_pkg.
`default_nettype none
module rmfh_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    input  wire logic                         i_out_free,
    input  wire logic                         i_command,
    input  wire logic [rmfh_pkg::TASK_W-1:0]  i_task_id,
    output logic                              o_req_ready,
    output logic                              o_res_load,
    output rmfh_pkg::t_result                 o_res
);
    import rmfh_pkg::*;

    typedef enum logic { S_IDLE, S_POP } t_state;

    t_state             r_state, n_state;
    logic [TASK_W-1:0]  r_owner, n_owner;
    logic               r_held, n_held;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               accept;
    logic               mem_we;
    logic [TASK_W-1:0]  mem_rdata;
    t_status            status;
    logic               woken;
    logic [DEPTH_W-1:0] dec_depth;

    rmfh_wait_ram #(
        .DEPTH (WAIT_DEPTH),
        .WIDTH (TASK_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (i_task_id),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign o_req_ready = (r_state == S_IDLE) && i_out_free;
    assign accept      = i_req_valid && o_req_ready;
    assign dec_depth   = (r_depth == '0) ? '0 : r_depth - DEPTH_W'(1);

    always_comb begin
        n_state    = r_state;
        n_owner    = r_owner;
        n_held     = r_held;
        n_depth    = r_depth;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        mem_we     = 1'b0;
        o_res_load = 1'b0;
        status     = ST_NOT_OWNER;
        woken      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_res_load = 1'b1;
                    if (t_cmd'(i_command) == CMD_LOCK) begin
                        if (!r_held) begin
                            n_held  = 1'b1;
                            n_owner = i_task_id;
                            n_depth = DEPTH_W'(1);
                            status  = ST_ACQUIRED;
                        end else if (r_owner == i_task_id) begin
                            if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                                status = ST_SATURATED;
                            end else begin
                                n_depth = r_depth + DEPTH_W'(1);
                                status  = ST_RELOCKED;
                            end
                        end else if (r_count >= CNT_W'(WAIT_DEPTH)) begin
                            status = ST_QFULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_tail  = next_slot(r_tail);
                            n_count = r_count + CNT_W'(1);
                            status  = ST_QUEUED;
                        end
                    end else if (r_held && r_owner == i_task_id) begin
                        n_depth = dec_depth;
                        if (dec_depth != '0) begin
                            status = ST_STILL_HELD;
                        end else if (r_count != '0) begin
                            // head entry arrives from the RAM next cycle
                            o_res_load = 1'b0;
                            n_state    = S_POP;
                        end else begin
                            n_held  = 1'b0;
                            n_owner = '0;
                            status  = ST_FREED;
                        end
                    end else begin
                        status = ST_NOT_OWNER;
                    end
                end
            end
            S_POP: begin
                o_res_load = 1'b1;
                n_owner    = mem_rdata;
                n_depth    = DEPTH_W'(1);
                n_head     = next_slot(r_head);
                n_count    = r_count - CNT_W'(1);
                woken      = 1'b1;
                status     = ST_HANDOFF;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.status      = status;
        o_res.woken_valid = woken;
        o_res.woken_task  = woken ? mem_rdata : '0;
        o_res.lock_depth  = n_held ? to_lock_depth(n_depth) : '0;
        o_res.owner_task  = n_held ? n_owner : '0;
        o_res.owned       = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_owner <= '0;
            r_held  <= 1'b0;
            r_depth <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_owner <= n_owner;
            r_held  <= n_held;
            r_depth <= n_depth;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end
endmodule
`default_nettype wire

### rtl/recursive_mutex_fifo_handoff_top.sv
// Recursive mutex with a FIFO wait queue: each request transfer (lock or unlock from a
// task) yields one result transfer. An unlock that hands the mutex to the oldest waiter
// goes on through the S_POP state, because the waiter comes from the wait-queue RAM,
// whose read data is registered. The result sits in an output register, so the next
// request is taken while that result is being taken. No clearing pass after reset.
// Depends on rmfh_pkg, rmfh_ctrl and rmfh_wait_ram.
`default_nettype none
module recursive_mutex_fifo_handoff_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_command,
    input  wire logic [rmfh_pkg::TASK_W-1:0]  i_task_id,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rmfh_pkg::STAT_W-1:0]       o_status,
    output logic                              o_woken_valid,
    output logic [rmfh_pkg::TASK_W-1:0]       o_woken_task,
    output logic [rmfh_pkg::LDEP_W-1:0]       o_lock_depth,
    output logic [rmfh_pkg::TASK_W-1:0]       o_owner_task,
    output logic                              o_owned
);
    import rmfh_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    res_load;
    t_result res;
    logic    out_free;

    assign out_free = !r_valid || i_ready;

    rmfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_out_free  (out_free),
        .i_command   (i_command),
        .i_task_id   (i_task_id),
        .o_req_ready (o_ready),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_res.status;
    assign o_woken_valid = r_res.woken_valid;
    assign o_woken_task  = r_res.woken_task;
    assign o_lock_depth  = r_res.lock_depth;
    assign o_owner_task  = r_res.owner_task;
    assign o_owned       = r_res.owned;
endmodule
`default_nettype wire

### rtl/rmfh_checker.sv
// Port-level checks for recursive_mutex_fifo_handoff_top, bound to the top level.
// Depends on rmfh_pkg.
`default_nettype none
module rmfh_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [rmfh_pkg::STAT_W-1:0]  o_status,
    input wire logic                         o_woken_valid,
    input wire logic [rmfh_pkg::TASK_W-1:0]  o_woken_task,
    input wire logic [rmfh_pkg::LDEP_W-1:0]  o_lock_depth,
    input wire logic [rmfh_pkg::TASK_W-1:0]  o_owner_task,
    input wire logic                         o_owned
);
    import rmfh_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_owner_task)
            && $stable(o_lock_depth))
        else $error("result changed while stalled");

    a_woken_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_woken_valid == (o_status == ST_HANDOFF))
            && (o_woken_valid || o_woken_task == '0))
        else $error("woken fields disagree with status");

    a_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_owned |-> o_lock_depth == '0 && o_owner_task == '0
            && (o_status == ST_FREED || o_status == ST_NOT_OWNER))
        else $error("free mutex reports owner or depth");

    a_new_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ACQUIRED || o_status == ST_HANDOFF)
            |-> o_owned && o_lock_depth == LDEP_W'(1))
        else $error("new owner without depth one");
endmodule

bind recursive_mutex_fifo_handoff_top rmfh_checker u_rmfh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_woken_valid (o_woken_valid),
    .o_woken_task  (o_woken_task),
    .o_lock_depth  (o_lock_depth),
    .o_owner_task  (o_owner_task),
    .o_owned       (o_owned)
);
`default_nettype wire
